// ----- rtl/rse_pkg.sv -----
`timescale 1ns / 1ps

package rse_pkg;

   // payload widths
   localparam int ID_W    = 16;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 7;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_RAISE = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_POLL  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic sample;   // register the compare result
      logic shift;    // take the entry of the right neighbor
      logic load;     // store the raised identifier
   } cell_ctrl_type;

endpackage

// ----- rtl/rse_req_if.sv -----
`timescale 1ns / 1ps

interface rse_req_if;
   logic                      valid;
   logic                      ready;
   logic [rse_pkg::KIND_W-1:0] kind;
   logic [rse_pkg::ID_W-1:0]   event_id;

   modport source (output valid, output kind, output event_id, input ready);
   modport sink   (input valid, input kind, input event_id, output ready);
endinterface

// ----- rtl/rse_rsp_if.sv -----
`timescale 1ns / 1ps

interface rse_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic                        refused_full;
   logic                        sticky_full;
   logic [rse_pkg::COUNT_W-1:0] entry_count;

   modport source (output valid, output ok, output refused_full, output sticky_full,
                   output entry_count, input ready);
   modport sink   (input valid, input ok, input refused_full, input sticky_full,
                   input entry_count, output ready);
endinterface

// ----- rtl/rse_cell.sv -----
`timescale 1ns / 1ps

module rse_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rse_pkg::cell_ctrl_type      ctrl,
   input  logic [rse_pkg::ID_W-1:0]    cmp_id,
   input  logic [rse_pkg::ID_W-1:0]    load_id,
   input  logic [CW-1:0]               count,
   input  logic [rse_pkg::ID_W-1:0]    right_entry,
   output logic [rse_pkg::ID_W-1:0]    entry,
   output logic                        match
);
   import rse_pkg::*;

   logic [ID_W-1:0] entry_ff, entry_in;
   logic            match_ff, match_in;

   // compare against the incoming identifier, only for held slots
   assign match_in = (entry_ff == cmp_id) && (CW'(INDEX) < count);

   // load a raised identifier or close the gap left by a poll
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = load_id;
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctrl.sample) begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ----- rtl/raised_event_set.sv -----
`timescale 1ns / 1ps

// channel   | direction | fields
// ----------+-----------+-----------------------------------------------
// req_if    | in        | kind, event_id
// rsp_if    | out       | ok, refused_full, sticky_full, entry_count
//
// in each transaction, at acceptance every cell compares its entry
// with the identifier, the next cycle applies raise, poll shift, or clear
// and loads the result register. the first match is picked by a priority mask
// over the row of cells. a new request is taken in the cycle the result is
// taken. reset empties the list and clears the sticky full flag; entries keep
// their contents. a stalled result holds the block until it is taken.

module raised_event_set #(
   parameter int CAPACITY = 64
) (
   input  logic     clock,
   input  logic     reset,
   rse_req_if.sink  req_if,
   rse_rsp_if.source rsp_if
);
   import rse_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      STATE_IDLE  = 2'b01,
      STATE_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in;
   logic             full_ff, full_in;
   kind_type         kind_ff;
   logic [ID_W-1:0]  id_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             ok_ff, ok_in;
   logic             refused_ff, refused_in;
   logic             sticky_ff, sticky_in;
   logic [COUNT_W-1:0] cnt_out_ff, cnt_out_in;

   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] low_vec;
   logic [CAPACITY-1:0] ge_vec;
   logic [ID_W-1:0]     entries [CAPACITY];

   logic accept;
   logic any_match;
   logic is_full;
   logic raise_go;
   logic poll_go;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_if.ready);

   // first match and everything to its right
   assign any_match = |match_vec;
   assign low_vec   = match_vec & (~match_vec + CAPACITY'(1));
   assign ge_vec    = ~(low_vec - CAPACITY'(1));

   assign is_full  = (count_ff >= CW'(CAPACITY));
   assign raise_go = (state_ff == STATE_APPLY) && (kind_ff == KIND_RAISE) && !is_full;
   assign poll_go  = (state_ff == STATE_APPLY) && (kind_ff == KIND_POLL) && any_match;

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctrl_type ctrl;
      logic [ID_W-1:0] right_entry;

      assign ctrl.sample = accept;
      assign ctrl.shift  = poll_go && ge_vec[i];
      assign ctrl.load   = raise_go && (count_ff == CW'(i));

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      rse_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cmp_id      (req_if.event_id),
         .load_id     (id_ff),
         .count       (count_ff),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .match       (match_vec[i])
      );
   end

   // sequencer and list state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      refused_in   = refused_ff;
      sticky_in    = sticky_ff;
      cnt_out_in   = cnt_out_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               state_in = STATE_APPLY;
            end
         end
         STATE_APPLY: begin
            ok_in      = 1'b0;
            refused_in = 1'b0;
            case (kind_ff)
               KIND_RAISE: begin
                  if (is_full) begin
                     refused_in = 1'b1;
                     full_in    = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                     ok_in    = 1'b1;
                  end
               end
               KIND_QUERY: begin
                  ok_in = any_match;
               end
               KIND_POLL: begin
                  if (any_match) begin
                     count_in = count_ff - CW'(1);
                     ok_in    = 1'b1;
                  end
               end
               KIND_CLEAR: begin
                  count_in = '0;
                  ok_in    = 1'b1;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
            sticky_in    = full_in;
            cnt_out_in   = COUNT_W'(count_in);
            rsp_valid_in = 1'b1;
            state_in     = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_if.kind);
         id_ff   <= req_if.event_id;
      end
      ok_ff      <= ok_in;
      refused_ff <= refused_in;
      sticky_ff  <= sticky_in;
      cnt_out_ff <= cnt_out_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ok           = ok_ff;
   assign rsp_if.refused_full = refused_ff;
   assign rsp_if.sticky_full  = sticky_ff;
   assign rsp_if.entry_count  = cnt_out_ff;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import rse_pkg::*;

   localparam int LIST_DEPTH = 64;

   // one expected response transaction
   typedef struct {
      bit             ok;
      bit             refused_full;
      bit             sticky_full;
      logic [COUNT_W-1:0] entry_count;
   } outcome_type;

   // mirror of the event list plus the queue of outcomes still owed
   class event_list_scoreboard;
      logic [ID_W-1:0] held_ids[$];
      bit              full_flag;
      outcome_type     pending_outcomes[$];
      int              fails;

      function new();
         full_flag = 0;
         fails     = 0;
      endfunction

      // apply one accepted request to the mirror and queue its outcome
      function void note_request(kind_type kind, logic [ID_W-1:0] event_id);
         outcome_type o;
         int          hit;
         o.ok           = 0;
         o.refused_full = 0;
         hit            = -1;
         foreach (held_ids[i]) begin
            if (hit < 0 && held_ids[i] == event_id) begin
               hit = i;
            end
         end
         case (kind)
            KIND_RAISE: begin
               if (held_ids.size() >= LIST_DEPTH) begin
                  o.refused_full = 1;
                  full_flag      = 1;
               end else begin
                  held_ids.push_back(event_id);
                  o.ok = 1;
               end
            end
            KIND_QUERY: begin
               o.ok = (hit >= 0);
            end
            KIND_POLL: begin
               // only the oldest match goes, order of the rest is kept
               if (hit >= 0) begin
                  held_ids.delete(hit);
                  o.ok = 1;
               end
            end
            default: begin
               held_ids.delete();
               o.ok = 1;
            end
         endcase
         o.sticky_full = full_flag;
         o.entry_count = COUNT_W'(held_ids.size());
         pending_outcomes.push_back(o);
      endfunction

      // compare one accepted response with the oldest expectation
      function void check_result(bit ok, bit refused_full, bit sticky_full,
                                 logic [COUNT_W-1:0] entry_count);
         outcome_type e;
         if (pending_outcomes.size() == 0) begin
            $error("response transaction with no request outstanding");
            fails++;
            return;
         end
         e = pending_outcomes.pop_front();
         if (ok !== e.ok) begin
            $error("ok: expected %0d, actual %0d", e.ok, ok);
            fails++;
         end
         if (refused_full !== e.refused_full) begin
            $error("refused_full: expected %0d, actual %0d", e.refused_full, refused_full);
            fails++;
         end
         if (sticky_full !== e.sticky_full) begin
            $error("sticky_full: expected %0d, actual %0d", e.sticky_full, sticky_full);
            fails++;
         end
         if (entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", e.entry_count, entry_count);
            fails++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   no_idle;

   rse_req_if req_if ();
   rse_rsp_if rsp_if ();

   event_list_scoreboard sb;

   raised_event_set #(
      .CAPACITY(LIST_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side stalls about 16 percent of the time, never while no_idle is set
   always @(posedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 16);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_result(rsp_if.ok, rsp_if.refused_full, rsp_if.sticky_full,
                         rsp_if.entry_count);
      end
   end

   // present one request, hold it until taken, then maybe leave a gap
   task automatic send_request(kind_type kind, logic [ID_W-1:0] event_id);
      int gap;
      req_if.valid    <= 1'b1;
      req_if.kind     <= kind;
      req_if.event_id <= event_id;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(kind, event_id);
      if (!no_idle && $urandom_range(0, 99) < 16) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // pick an operation from a weight on raise, rest split query/poll, a few clears
   function automatic kind_type pick_kind(int raise_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < raise_pct) return KIND_RAISE;
      if (r < raise_pct + (97 - raise_pct) / 2) return KIND_QUERY;
      if (r < 97) return KIND_POLL;
      return KIND_CLEAR;
   endfunction

   // watchdog
   initial begin
      #3ms;
      $display("FAIL raised_event_set");
      $finish;
   end

   initial begin
      logic [ID_W-1:0] id_pool[8];
      int              raise_pct;
      logic [ID_W-1:0] id;

      sb = new();
      no_idle         = 0;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_RAISE;
      req_if.event_id <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: id extremes, duplicates, misses, clear and empty list
      send_request(KIND_POLL,  16'h0001);
      send_request(KIND_QUERY, 16'h0000);
      send_request(KIND_RAISE, 16'h0000);
      send_request(KIND_RAISE, 16'hffff);
      send_request(KIND_RAISE, 16'h1234);
      send_request(KIND_RAISE, 16'h1234);
      send_request(KIND_RAISE, 16'h00aa);
      send_request(KIND_QUERY, 16'hffff);
      send_request(KIND_QUERY, 16'h5555);
      send_request(KIND_POLL,  16'h1234);
      send_request(KIND_QUERY, 16'h1234);
      send_request(KIND_POLL,  16'h5555);
      send_request(KIND_POLL,  16'h0000);
      send_request(KIND_QUERY, 16'h0000);
      send_request(KIND_CLEAR, 16'hffff);
      send_request(KIND_QUERY, 16'hffff);
      send_request(KIND_POLL,  16'h00aa);
      send_request(KIND_RAISE, 16'hfffe);
      send_request(KIND_CLEAR, 16'h0000);

      // directed: fill past capacity, free the oldest slot and refill
      for (int k = 0; k < LIST_DEPTH + 2; k++) begin
         send_request(KIND_RAISE, ID_W'(k));
      end
      send_request(KIND_QUERY, ID_W'(LIST_DEPTH - 1));
      send_request(KIND_POLL,  16'h0000);
      send_request(KIND_RAISE, 16'hbeef);
      send_request(KIND_RAISE, 16'hbeee);
      send_request(KIND_QUERY, 16'hbeef);
      send_request(KIND_CLEAR, 16'h0000);

      // random: phases that fill, drain or mix, ids mostly from a small pool
      raise_pct = 40;
      for (int n = 0; n < 1000; n++) begin
         if (n % 120 == 0) begin
            case ($urandom_range(0, 2))
               0: raise_pct = 75;
               1: raise_pct = 20;
               default: raise_pct = 45;
            endcase
            foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 65535));
         end
         no_idle = (n >= 450 && n < 650);
         if ($urandom_range(0, 99) < 80) id = id_pool[$urandom_range(0, 7)];
         else id = ID_W'($urandom_range(0, 65535));
         send_request(pick_kind(raise_pct), id);
      end
      req_if.valid <= 1'b0;

      while (sb.pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fails == 0) begin
         $display("PASS raised_event_set");
      end else begin
         $display("FAIL raised_event_set");
      end
      $finish;
   end

endmodule
